FILE: src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/hcbd_pkg.sv
// types, codes and helper functions for the chunked body decoder
// no dependencies
package hcbd_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    localparam logic [1:0] ST_BUSY     = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_DATA,
        PH_END_CR,
        PH_END_LF,
        PH_TRAILER,
        PH_COMPLETE,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        SS_WS,
        SS_SIGN,
        SS_ZERO,
        SS_PREFIX,
        SS_DIGITS,
        SS_EXT
    } subphase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == CH_CR;
    endfunction

endpackage

FILE: src/http_chunked_body_decoder.sv
// chunked transfer-coding body decoder: one result word per input byte, with payload
// flag and a sticky status (in progress, complete, error)
// depends on hcbd_pkg
//
// Takes one byte per cycle while the output is not stalled and returns one word per byte.
// The word stays on the output while the output is stalled. The path is an input
// register, then the per-byte state update, then the result register. The state update
// is a single hex-digit shift and compare on the chunk length counter, so a byte may
// enter in every cycle in which the output is not stalled. Complete and error stay
// until reset; later bytes give no payload.
module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] body_byte,
    output logic       body_valid,
    output logic [1:0] status
);

    logic                 s1_valid_reg;
    logic [7:0]           s1_byte_reg;
    logic                 out_valid_reg;
    logic [7:0]           body_byte_reg;
    logic                 body_valid_reg;
    logic [1:0]           status_reg;

    phase_t               phase_reg, phase_next;
    subphase_t            sub_reg, sub_next;
    logic [SIZE_BITS-1:0] len_reg, len_next;
    logic                 pending_cr_reg, pending_cr_next;
    logic                 has_text_reg, has_text_next;

    logic [7:0]           body_byte_next;
    logic                 body_valid_next;
    logic [1:0]           status_next;

    logic                 out_free;
    logic                 step;
    logic [7:0]           c;
    hex_t                 hx;
    logic                 digit_ok;

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign c        = s1_byte_reg;
    assign hx       = hex_decode(c);
    assign digit_ok = hx.ok && (len_reg[SIZE_BITS-1 -: 4] == 4'd0);

    assign out_valid  = out_valid_reg;
    assign body_byte  = body_byte_reg;
    assign body_valid = body_valid_reg;
    assign status     = status_reg;

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        sub_next        = sub_reg;
        len_next        = len_reg;
        pending_cr_next = pending_cr_reg;
        has_text_next   = has_text_reg;
        unique case (phase_reg)
            PH_SIZE:
            begin
                if (pending_cr_reg) begin
                    pending_cr_next = 1'b0;
                    if (c == CH_LF) begin
                        sub_next = SS_WS;
                        if (len_reg == '0) begin
                            phase_next    = PH_TRAILER;
                            has_text_next = 1'b0;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end else begin
                        phase_next = PH_ERROR;
                    end
                end else begin
                    unique case (sub_reg)
                        SS_WS, SS_SIGN:
                        begin
                            if (sub_reg == SS_WS && is_blank(c)) begin
                                sub_next = SS_WS;
                            end else if (sub_reg == SS_WS && c == CH_PLUS) begin
                                sub_next = SS_SIGN;
                            end else if (c == CH_ZERO) begin
                                sub_next = SS_ZERO;
                            end else if (digit_ok) begin
                                len_next = {len_reg[SIZE_BITS-5:0], hx.val};
                                sub_next = SS_DIGITS;
                            end else begin
                                phase_next = PH_ERROR;
                            end
                        end
                        SS_PREFIX:
                        begin
                            if (digit_ok) begin
                                len_next = {len_reg[SIZE_BITS-5:0], hx.val};
                                sub_next = SS_DIGITS;
                            end else begin
                                phase_next = PH_ERROR;
                            end
                        end
                        SS_ZERO, SS_DIGITS:
                        begin
                            if (sub_reg == SS_ZERO && (c == CH_LOW_X || c == CH_UP_X)) begin
                                sub_next = SS_PREFIX;
                            end else if (c == CH_LF) begin
                                sub_next = SS_WS;
                                if (len_reg == '0) begin
                                    phase_next    = PH_TRAILER;
                                    has_text_next = 1'b0;
                                end else begin
                                    phase_next = PH_DATA;
                                end
                            end else if (c == CH_CR) begin
                                pending_cr_next = 1'b1;
                            end else if (c == CH_SEMI) begin
                                sub_next = SS_EXT;
                            end else if (digit_ok) begin
                                len_next = {len_reg[SIZE_BITS-5:0], hx.val};
                                sub_next = SS_DIGITS;
                            end else begin
                                phase_next = PH_ERROR;
                            end
                        end
                        SS_EXT:
                        begin
                            if (c == CH_LF) begin
                                sub_next = SS_WS;
                                if (len_reg == '0) begin
                                    phase_next    = PH_TRAILER;
                                    has_text_next = 1'b0;
                                end else begin
                                    phase_next = PH_DATA;
                                end
                            end
                        end
                        default: phase_next = PH_ERROR;
                    endcase
                end
            end
            PH_DATA:
            begin
                // len counts down the bytes still due in this chunk
                len_next = len_reg - SIZE_BITS'(1);
                if (len_reg == SIZE_BITS'(1)) begin
                    phase_next = PH_END_CR;
                end
            end
            PH_END_CR:
            begin
                if (c == CH_CR) begin
                    phase_next = PH_END_LF;
                end else if (c == CH_LF) begin
                    phase_next      = PH_SIZE;
                    sub_next        = SS_WS;
                    len_next        = '0;
                    pending_cr_next = 1'b0;
                end else begin
                    phase_next = PH_ERROR;
                end
            end
            PH_END_LF:
            begin
                if (c == CH_LF) begin
                    phase_next      = PH_SIZE;
                    sub_next        = SS_WS;
                    len_next        = '0;
                    pending_cr_next = 1'b0;
                end else begin
                    phase_next = PH_ERROR;
                end
            end
            PH_TRAILER:
            begin
                if (c == CH_LF) begin
                    if (!has_text_reg) begin
                        phase_next = PH_COMPLETE;
                    end
                    has_text_next   = 1'b0;
                    pending_cr_next = 1'b0;
                end else if (c == CH_CR) begin
                    // a cr that is not followed by lf counts as text
                    pending_cr_next = 1'b1;
                    has_text_next   = has_text_reg || pending_cr_reg;
                end else begin
                    pending_cr_next = 1'b0;
                    has_text_next   = 1'b1;
                end
            end
            PH_COMPLETE: phase_next = PH_COMPLETE;
            PH_ERROR:    phase_next = PH_ERROR;
            default:     phase_next = PH_ERROR;
        endcase
    end

    // result word
    always_comb
    begin
        body_valid_next = (phase_reg == PH_DATA);
        body_byte_next  = (phase_reg == PH_DATA) ? c : 8'd0;
        unique case (phase_next)
            PH_COMPLETE: status_next = ST_COMPLETE;
            PH_ERROR:    status_next = ST_ERROR;
            default:     status_next = ST_BUSY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_SIZE;
            sub_reg        <= SS_WS;
            len_reg        <= '0;
            pending_cr_reg <= 1'b0;
            has_text_reg   <= 1'b0;
        end else begin
            if (!in_stall) begin
                s1_valid_reg <= in_valid;
            end
            if (out_free) begin
                out_valid_reg <= s1_valid_reg;
            end
            if (step) begin
                phase_reg      <= phase_next;
                sub_reg        <= sub_next;
                len_reg        <= len_next;
                pending_cr_reg <= pending_cr_next;
                has_text_reg   <= has_text_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid) begin
            s1_byte_reg <= in_byte;
        end
        if (step) begin
            body_byte_reg  <= body_byte_next;
            body_valid_reg <= body_valid_next;
            status_reg     <= status_next;
        end
    end

endmodule

FILE: src/hcbd_checker.sv
// port-level checks for the chunked body decoder, bound to the top level
// depends on hcbd_pkg and assert_macros.svh
`include "assert_macros.svh"

module hcbd_checker
    import hcbd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] body_byte,
    input logic       body_valid,
    input logic [1:0] status
);

    // payload only while the body is still in progress
    `ASSERT_IMPLIES(a_payload_busy, clk, rst_n, out_valid && body_valid, status == ST_BUSY)

    // a word without payload carries a zero byte
    `ASSERT_IMPLIES(a_idle_byte, clk, rst_n, out_valid && !body_valid, body_byte == 8'd0)

    // complete and error hold for every later word
    `ASSERT_NEXT(a_sticky, clk, rst_n, out_valid && !out_stall && status != ST_BUSY,
        !out_valid || status == $past(status))

    // a stalled word holds
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(body_byte) && $stable(body_valid) && $stable(status))

    // input stalls only behind a stalled output word
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);
